/* src/stxb_pkg.sv */
// Shared codes, types and constants for the STX/length/BCC frame receiver.
package stxb_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_REOPEN = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    // Output item kinds
    localparam logic OUT_FRAME = 1'b0;
    localparam logic OUT_TX    = 1'b1;

    // Protocol bytes
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_ENQ = 8'h05;

    // Frame length rules: overhead plus data length, fixed length for empty data
    localparam logic [16:0] FLEN_OVERHEAD = 17'd5;
    localparam logic [16:0] FLEN_EMPTY    = 17'd12;
    localparam logic [16:0] FLEN_MIN_CNT  = 17'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_enq;
        logic rd_start;
        logic load_frame;
        logic rd_advance;
    } cmd_t;

    typedef struct packed {
        logic frame_ok;
        logic ack;
        logic out_last;
    } status_t;

endpackage

/* src/stxb_datapath.sv */
// Datapath: frame store, fill count, running BCC, length capture and output registers.
module stxb_datapath
    import stxb_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    output logic       out_kind,
    output logic [7:0] data,
    output logic       last,
    output logic [6:0] frame_length
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [7:0]    store_mem [STORE_DEPTH];

    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    bcc_reg, bcc_next;
    logic [7:0]    dlen_hi_reg;
    logic [7:0]    dlen_lo_reg;
    logic          open_reg, open_next;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] last_idx_reg;
    logic [7:0]    rd_data_reg;
    logic          out_kind_reg;
    logic [7:0]    data_reg;
    logic          last_reg;
    logic [6:0]    frame_length_reg;

    logic          is_byte;
    logic          at_head;
    logic [AW-1:0] cnt_new;
    logic [15:0]   dlen;
    logic [16:0]   flen;
    logic [16:0]   cnt_wide;
    logic          check;
    logic          frame_ok;
    logic          ack;

    // Decode the incoming item against the current fill state
    always_comb
    begin
        is_byte  = (kind == KIND_BYTE) && open_reg;
        at_head  = (idx_reg == '0);
        cnt_new  = (idx_reg == AW'(STORE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
        cnt_wide = 17'(cnt_new);
        bcc_next = at_head ? rx_byte : (bcc_reg ^ rx_byte);
        dlen     = {dlen_hi_reg, dlen_lo_reg};
        flen     = (dlen == 16'd0) ? FLEN_EMPTY : (17'(dlen) + FLEN_OVERHEAD);
        // Past the head the first stored byte is always STX
        check    = !at_head && (cnt_wide > FLEN_MIN_CNT) && (cnt_wide >= flen);
        frame_ok = is_byte && check && (bcc_next == 8'h00);
        ack      = is_byte && at_head && (rx_byte == BYTE_ACK);
    end

    // Advance or clear the fill count
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept && is_byte)
        begin
            if (at_head)
                idx_next = (rx_byte == BYTE_STX) ? cnt_new : '0;
            else
                idx_next = check ? '0 : cnt_new;
        end
    end

    // Open on reopen, close after an accepted frame
    always_comb
    begin
        open_next = open_reg;
        if (cmd.accept && (kind == KIND_REOPEN))
            open_next = 1'b1;
        else if (cmd.accept && frame_ok)
            open_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            open_reg   <= 1'b1;
            rd_idx_reg <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            open_reg <= open_next;
            if (cmd.rd_start)
                rd_idx_reg <= '0;
            else if (cmd.rd_advance)
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    // Capture running BCC and length bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcc_reg     <= '0;
            dlen_hi_reg <= '0;
            dlen_lo_reg <= '0;
        end
        else if (cmd.accept && is_byte)
        begin
            bcc_reg <= bcc_next;
            if (idx_reg == AW'(1))
                dlen_hi_reg <= rx_byte;
            if (idx_reg == AW'(2))
                dlen_lo_reg <= rx_byte;
        end
    end

    // Write and read the frame store
    always_ff @(posedge clk)
    begin
        if (cmd.accept && is_byte)
            store_mem[idx_reg] <= rx_byte;
        rd_data_reg <= store_mem[rd_idx_reg];
    end

    // Load output item registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && frame_ok)
        begin
            last_idx_reg     <= AW'(flen - 17'd1);
            out_kind_reg     <= OUT_FRAME;
            frame_length_reg <= flen[6:0];
        end
        else if (cmd.load_enq)
        begin
            out_kind_reg     <= OUT_TX;
            data_reg         <= BYTE_ENQ;
            last_reg         <= 1'b1;
            frame_length_reg <= 7'd0;
        end
        else if (cmd.load_frame)
        begin
            data_reg <= rd_data_reg;
            last_reg <= (rd_idx_reg == last_idx_reg);
        end
    end

    assign status.frame_ok = frame_ok;
    assign status.ack      = ack;
    assign status.out_last = last_reg;

    assign out_kind     = out_kind_reg;
    assign data         = data_reg;
    assign last         = last_reg;
    assign frame_length = frame_length_reg;

endmodule

/* src/stxb_ctrl.sv */
// Controller: sequences byte intake, enquiry reply and frame emission.
module stxb_ctrl
    import stxb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // Choose next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.frame_ok)
                    state_next = ST_READ;
                else if (in_valid && status.ack)
                    state_next = ST_SEND;
            end
            ST_READ:
                state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_SEND;
            ST_SEND:
            begin
                if (!out_stall)
                    state_next = status.out_last ? ST_IDLE : ST_READ;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Drive handshake and datapath commands
    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.accept   = in_valid;
                cmd.load_enq = in_valid && status.ack;
                cmd.rd_start = in_valid && status.frame_ok;
            end
            ST_LOAD:
                cmd.load_frame = 1'b1;
            ST_SEND:
            begin
                out_valid      = 1'b1;
                cmd.rd_advance = !out_stall && !status.out_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // One item at a time: no intake while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken while output item pending");

    // A loaded frame byte is offered in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> out_valid)
        else $error("loaded frame byte not offered");

    // A stalled output item stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled output item withdrawn");

    // Frame start and enquiry reply never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_start && cmd.load_enq))
        else $error("frame start and enquiry reply together");

endmodule

/* src/stx_length_bcc_frame_receiver_core.sv */
// Top level of the STX/length/BCC frame receiver.
//
// Input channel (in_valid/in_stall, kind, rx_byte) takes one UART event per
// item: a received byte, a byte with line error (dropped) or a reopen.
// Output channel (out_valid/out_stall, out_kind, data, last, frame_length)
// delivers either the bytes of a frame whose BCC matched, in store order
// with last on the final byte, or a single transmit byte 0x05 after an ACK.
// A byte item is taken at once when no result is pending. An enquiry
// reply is offered the cycle after its byte. A good frame is read back from
// the frame store byte by byte (address, registered read, output load), and
// each byte waits while the receiver holds out_stall before the next is read.
// in_stall stays high from the closing byte until the last result is taken.
// After an accepted frame reception stays closed until a reopen item.
// Reset clears the fill count and opens reception; the store is not cleared.
// While out_stall is high the offered item holds unchanged.
module stx_length_bcc_frame_receiver_core
    import stxb_pkg::*;
#(
    parameter int STORE_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_kind,
    output logic [7:0] data,
    output logic       last,
    output logic [6:0] frame_length
);

    cmd_t    cmd;
    status_t status;

    // Sequence intake and emission
    stxb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Store, check and present items
    stxb_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .out_kind     (out_kind),
        .data         (data),
        .last         (last),
        .frame_length (frame_length)
    );

endmodule

/* tb/stx_length_bcc_frame_receiver_core_test.sv */
// Self-checking test of the STX/length/BCC frame receiver: directed cases, then random traffic.
`timescale 1ns / 100ps

module stx_length_bcc_frame_receiver_core_test;
    import stxb_pkg::*;

    localparam int STORE_DEPTH = 64;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] frame_length;
    } reply_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       out_kind;
    logic [7:0] data;
    logic       last;
    logic [6:0] frame_length;

    // Receiver mirror: byte store, fill count, reception gate
    logic [7:0] frame_mem [STORE_DEPTH];
    int         fill_cnt;
    bit         rx_open;

    reply_t     reply_queue [$];
    int         errors;
    int         taken_count;
    bit         idle_on;
    int         stall_left;
    event       item_taken;

    stx_length_bcc_frame_receiver_core #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .data        (data),
        .last        (last),
        .frame_length(frame_length)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    // Work out the replies caused by one accepted item and queue them
    function automatic void predict_replies(logic [1:0] k, logic [7:0] b);
        logic [15:0] dlen;
        logic [16:0] flen;
        logic [7:0]  bcc;
        reply_t      r;
        int          i;
        if (k == KIND_REOPEN)
        begin
            rx_open = 1'b1;
            return;
        end
        if (k != KIND_BYTE || !rx_open)
            return;
        frame_mem[fill_cnt] = b;
        fill_cnt++;
        if (fill_cnt >= STORE_DEPTH)
            fill_cnt = 0;
        if (frame_mem[0] == BYTE_STX)
        begin
            if (fill_cnt > 2)
            begin
                dlen = {frame_mem[1], frame_mem[2]};
                flen = (dlen == 16'd0) ? FLEN_EMPTY : FLEN_OVERHEAD + 17'(dlen);
                if (fill_cnt >= flen)
                begin
                    bcc = 8'h00;
                    for (i = 0; i + 1 < flen; i++)
                        bcc ^= frame_mem[i];
                    if (bcc == frame_mem[flen - 1])
                    begin
                        rx_open = 1'b0;
                        for (i = 0; i < flen; i++)
                        begin
                            r.out_kind     = OUT_FRAME;
                            r.data         = frame_mem[i];
                            r.last         = (i + 1 == flen);
                            r.frame_length = flen[6:0];
                            reply_queue.push_back(r);
                        end
                    end
                    fill_cnt = 0;
                end
            end
        end
        else if (frame_mem[0] == BYTE_ACK)
        begin
            r.out_kind     = OUT_TX;
            r.data         = BYTE_ENQ;
            r.last         = 1'b1;
            r.frame_length = 7'd0;
            reply_queue.push_back(r);
            fill_cnt = 0;
        end
        else
        begin
            fill_cnt = 0;
        end
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Check each taken result, then predict for each taken input item
    always @(posedge clk)
    begin : monitor
        reply_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (reply_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d data %02h",
                             $time, out_kind, data);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    check_field("out_kind", want.out_kind, out_kind);
                    check_field("data", want.data, data);
                    check_field("last", want.last, last);
                    check_field("frame_length", want.frame_length, frame_length);
                end
            end
            if (in_valid && !in_stall)
            begin
                taken_count++;
                predict_replies(kind, rx_byte);
                -> item_taken;
            end
        end
    end

    // Hold off results in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 16);
        out_stall <= idle_on && (stall_left > 0);
    end

    // Offer one item, with an optional idle burst ahead, and wait until it is taken
    task automatic send_item(logic [1:0] k, logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        @(item_taken);
    endtask

    // Send a well-formed frame with random content; optionally spoil the BCC
    task automatic send_frame(logic [15:0] dlen, bit good_bcc);
        logic [7:0] body [$];
        logic [7:0] bcc;
        int         flen;
        int         i;
        flen = (dlen == 16'd0) ? 12 : 5 + dlen;
        body = {BYTE_STX, dlen[15:8], dlen[7:0]};
        for (i = 3; i < flen - 1; i++)
            body.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1)
            body[flen - 2] = 8'h03;
        bcc = 8'h00;
        foreach (body[j])
            bcc ^= body[j];
        if (!good_bcc)
            bcc ^= 8'($urandom_range(1, 255));
        body.push_back(bcc);
        foreach (body[j])
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(KIND_ERROR, 8'($urandom_range(0, 255)));
            send_item(KIND_BYTE, body[j]);
        end
    endtask

    task automatic test_enquiry_reply();
        send_item(KIND_BYTE, BYTE_ACK);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
    endtask

    task automatic test_line_error_in_frame();
        send_item(KIND_BYTE, BYTE_STX);
        send_item(KIND_ERROR, BYTE_STX);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h03);
        send_item(KIND_BYTE, BYTE_STX ^ 8'h01 ^ 8'hFF ^ 8'h03);
    endtask

    task automatic test_closed_reception();
        send_item(KIND_BYTE, BYTE_ACK);
        send_item(KIND_SPARE, 8'hFF);
        send_item(KIND_REOPEN, 8'h00);
        send_item(KIND_BYTE, BYTE_ACK);
    endtask

    task automatic test_bad_bcc();
        send_item(KIND_BYTE, BYTE_STX);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'h03);
        send_item(KIND_BYTE, BYTE_STX ^ 8'h01 ^ 8'h03 ^ 8'h01);
        send_item(KIND_BYTE, BYTE_ACK);
    endtask

    // Mostly framed traffic, with enquiries, noise, overlong frames and gate changes
    task automatic random_traffic(int count);
        int          stop_at;
        int          pick;
        int          n;
        logic [15:0] dlen;
        stop_at = taken_count + count;
        while (taken_count < stop_at)
        begin
            pick = $urandom_range(0, 99);
            // Drain a partial frame so the next one starts aligned
            while (rx_open && fill_cnt != 0)
                send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            if (pick < 55)
            begin
                if (!rx_open && $urandom_range(0, 6) != 0)
                    send_item(KIND_REOPEN, 8'($urandom_range(0, 255)));
                n = $urandom_range(0, 19);
                if (n == 0)
                    dlen = 16'd0;
                else if (n == 1)
                    dlen = 16'(STORE_DEPTH - 6);
                else
                    dlen = 16'($urandom_range(1, 12));
                send_frame(dlen, $urandom_range(0, 6) != 0);
            end
            else if (pick < 65)
            begin
                send_item(KIND_BYTE, BYTE_ACK);
            end
            else if (pick < 72)
            begin
                send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 75)
            begin
                // Length the fill count can never reach: it wraps instead
                send_item(KIND_BYTE, BYTE_STX);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item(KIND_BYTE, 8'($urandom_range(1, 255)));
                    send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
                end
                else
                begin
                    send_item(KIND_BYTE, 8'h00);
                    send_item(KIND_BYTE, 8'($urandom_range(STORE_DEPTH - 5, 255)));
                end
                repeat ($urandom_range(10, 70))
                    send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 84)
            begin
                send_item($urandom_range(0, 1) ? KIND_ERROR : KIND_SPARE,
                          8'($urandom_range(0, 255)));
            end
            else if (pick < 90)
            begin
                send_item(KIND_REOPEN, 8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_idle();
        idle_on = 1'b1;
        random_traffic(280);
    endtask

    task automatic test_random_steady();
        idle_on = 1'b0;
        random_traffic(60);
    endtask

    // Sequence the run
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_BYTE;
        rx_byte     = 8'h00;
        out_stall   = 1'b0;
        errors      = 0;
        taken_count = 0;
        idle_on     = 1'b1;
        stall_left  = 0;
        fill_cnt    = 0;
        rx_open     = 1'b1;
        foreach (frame_mem[i])
            frame_mem[i] = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_enquiry_reply();
        test_line_error_in_frame();
        test_closed_reception();
        test_bad_bcc();
        test_random_idle();
        test_random_steady();

        in_valid <= 1'b0;
        while (reply_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* stx_length_bcc_frame_receiver_core.f */
src/stxb_pkg.sv
src/stxb_datapath.sv
src/stxb_ctrl.sv
src/stx_length_bcc_frame_receiver_core.sv
tb/stx_length_bcc_frame_receiver_core_test.sv
